>>> hw/rtl/utd_pkg.sv
// Shared types and constants for the UTF-8 to UCS-2 decoder.
// No dependencies; used by the decode logic, the result queue and the top level.
package utd_pkg;

   // Byte classification limits.
   localparam logic [7:0] ASCII_MAX      = 8'h7f;
   localparam logic [7:0] LEAD2_MIN      = 8'hc2;
   localparam logic [7:0] LEAD3_MIN      = 8'he0;
   localparam logic [7:0] LEAD4_MIN      = 8'hf0;
   localparam logic [7:0] LEAD_LIMIT     = 8'hf5;
   localparam logic [7:0] LEAD2_MASK     = 8'h1f;
   localparam logic [7:0] LEAD3_MASK     = 8'h0f;
   localparam logic [7:0] LEAD4_MASK     = 8'h07;
   localparam logic [7:0] CONT_TAG_MASK  = 8'hc0;
   localparam logic [7:0] CONT_TAG       = 8'h80;

   localparam logic [15:0] REPLACEMENT_CHAR = 16'hfffd;

   localparam int ACCUM_W       = 21;
   localparam int RSP_DEPTH_DEF = 4;

   // One result word as it waits in the result queue.
   typedef struct packed {
      logic [15:0] code_point;
      logic        string_end;
      logic        last;
   } rsp_entry_type;

   // Everything the decode logic produces for one input byte.
   typedef struct packed {
      logic [1:0]         count;
      rsp_entry_type      res0;
      rsp_entry_type      res1;
      logic [1:0]         pending;
      logic [ACCUM_W-1:0] accum;
   } decode_out_type;

endpackage

>>> hw/rtl/utd_decode.sv
// Combinational decode of one byte against the open sequence state.
// Depends on utd_pkg for constants and the decode_out_type struct.
module utd_decode
   import utd_pkg::*;
(
   input  logic [7:0]         in_byte,
   input  logic [1:0]         pending,
   input  logic [ACCUM_W-1:0] accum,
   output decode_out_type     dec
);

   logic               lead_emit;
   logic [15:0]        lead_code;
   logic [1:0]         lead_pending;
   logic [ACCUM_W-1:0] lead_accum;
   logic [ACCUM_W-1:0] cont_accum;
   logic [1:0]         cont_pending;
   logic [15:0]        held_code;
   logic [15:0]        cont_code;
   logic               is_cont;

   // Lead byte classification with no sequence open.
   always_comb begin
      lead_emit    = 1'b0;
      lead_code    = REPLACEMENT_CHAR;
      lead_pending = 2'd0;
      lead_accum   = '0;
      if (in_byte <= ASCII_MAX) begin
         lead_emit = 1'b1;
         lead_code = {8'h00, in_byte};
      end else if (in_byte < LEAD2_MIN) begin
         lead_emit = 1'b1;
      end else if (in_byte < LEAD3_MIN) begin
         lead_pending = 2'd1;
         lead_accum   = ACCUM_W'(in_byte & LEAD2_MASK);
      end else if (in_byte < LEAD4_MIN) begin
         lead_pending = 2'd2;
         lead_accum   = ACCUM_W'(in_byte & LEAD3_MASK);
      end else if (in_byte < LEAD_LIMIT) begin
         lead_pending = 2'd3;
         lead_accum   = ACCUM_W'(in_byte & LEAD4_MASK);
      end else begin
         lead_emit = 1'b1;
      end
   end

   assign is_cont      = (in_byte & CONT_TAG_MASK) == CONT_TAG;
   assign cont_accum   = {accum[ACCUM_W-7:0], in_byte[5:0]};
   assign cont_pending = pending - 2'd1;
   // Values beyond the basic plane do not fit and become the replacement character.
   assign held_code    = (accum[ACCUM_W-1:16] != '0) ? REPLACEMENT_CHAR : accum[15:0];
   assign cont_code    = (cont_accum[ACCUM_W-1:16] != '0) ? REPLACEMENT_CHAR
                                                          : cont_accum[15:0];

   always_comb begin
      dec         = '0;
      dec.pending = pending;
      dec.accum   = accum;
      if (in_byte == 8'h00) begin
         dec.pending = 2'd0;
         dec.accum   = '0;
         if (pending != 2'd0) begin
            dec.count           = 2'd2;
            dec.res0.code_point = held_code;
            dec.res1.string_end = 1'b1;
         end else begin
            dec.count           = 2'd1;
            dec.res0.string_end = 1'b1;
         end
      end else if (pending != 2'd0) begin
         if (is_cont) begin
            dec.pending = cont_pending;
            if (cont_pending == 2'd0) begin
               dec.count           = 2'd1;
               dec.res0.code_point = cont_code;
               dec.accum           = '0;
            end else begin
               dec.accum = cont_accum;
            end
         end else begin
            // Broken sequence: report it, then treat this byte as a fresh lead.
            dec.res0.code_point = REPLACEMENT_CHAR;
            dec.pending         = lead_pending;
            dec.accum           = lead_accum;
            dec.res1.code_point = lead_code;
            dec.count           = lead_emit ? 2'd2 : 2'd1;
         end
      end else begin
         dec.pending         = lead_pending;
         dec.accum           = lead_accum;
         dec.res0.code_point = lead_code;
         dec.count           = lead_emit ? 2'd1 : 2'd0;
      end
      dec.res0.last = (dec.count == 2'd1);
      dec.res1.last = 1'b1;
   end

endmodule

>>> hw/rtl/utd_rsp_queue.sv
// Small result queue that takes up to two words per cycle and hands out one.
// Depends on utd_pkg for rsp_entry_type; DEPTH must be a power of two, at least 2.
module utd_rsp_queue
   import utd_pkg::*;
#(
   parameter int DEPTH = RSP_DEPTH_DEF
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic [1:0]                 push_count,
   input  rsp_entry_type              push0,
   input  rsp_entry_type              push1,
   input  logic                       pop,
   output rsp_entry_type              head,
   output logic                       head_valid,
   output logic [$clog2(DEPTH+1)-1:0] level
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsp_entry_type      mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push_count);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + CNT_W'(push_count) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_ptr_ff + PTR_W'(1)] <= push1;
      end
   end

   assign head       = mem_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign level      = count_ff;

endmodule

>>> hw/rtl/utf8_to_ucs2_decoder_core.sv
// UTF-8 to UCS-2 decoder core: sequence state registers, decode logic and result queue.
// Depends on utd_pkg, utd_decode and utd_rsp_queue.
//
// Usage: the sender offers one byte of a NUL-terminated UTF-8 string per word on
// req_valid/req_ready/req_in_byte. Each byte yields zero, one or two result words on
// rsp_valid/rsp_ready with rsp_code_point, rsp_string_end and rsp_last. A lead byte of a
// multi-byte sequence yields nothing; the final continuation yields the code point.
// Malformed bytes give U+FFFD, and a broken sequence gives U+FFFD followed by the
// decode of the offending byte as a new lead. A zero byte flushes any partial code and
// then gives the terminating zero word with rsp_string_end set. rsp_last marks the final
// word caused by a byte.
// A byte that is accepted is registered into the result queue, whose head drives the
// rsp ports. Throughput: one byte per cycle while req_ready is high; the result queue holds
// RSP_DEPTH words and takes a byte only while at least two slots are free, so a steady
// run of two-word bytes is held back by the single read port of the queue.
// When the receiver stalls, results collect in the queue and req_ready drops once
// fewer than two slots remain free; nothing is lost or repeated.
// Reset (synchronous, active high) closes any open sequence and empties the queue.
module utf8_to_ucs2_decoder_core
   import utd_pkg::*;
#(
   parameter int RSP_DEPTH = RSP_DEPTH_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_code_point,
   output logic        rsp_string_end,
   output logic        rsp_last
);

   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   logic [1:0]         pending_ff, pending_in;
   logic [ACCUM_W-1:0] accum_ff, accum_in;
   decode_out_type     dec;
   logic               req_take;
   logic [1:0]         push_count;
   rsp_entry_type      head;
   logic [CNT_W-1:0]   level;

   // A byte is taken only when the queue has room for the worst case of two words.
   assign req_ready = (level <= CNT_W'(RSP_DEPTH - 2));
   assign req_take  = req_valid && req_ready;

   utd_decode u_decode (
      .in_byte (req_in_byte),
      .pending (pending_ff),
      .accum   (accum_ff),
      .dec     (dec)
   );

   // The sequence state advances only on an accepted byte.
   assign pending_in = req_take ? dec.pending : pending_ff;
   assign accum_in   = req_take ? dec.accum   : accum_ff;
   assign push_count = req_take ? dec.count   : 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
         accum_ff   <= '0;
      end else begin
         pending_ff <= pending_in;
         accum_ff   <= accum_in;
      end
   end

   utd_rsp_queue #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push0      (dec.res0),
      .push1      (dec.res1),
      .pop        (rsp_valid && rsp_ready),
      .head       (head),
      .head_valid (rsp_valid),
      .level      (level)
   );

   assign rsp_code_point = head.code_point;
   assign rsp_string_end = head.string_end;
   assign rsp_last       = head.last;

`ifndef SYNTHESIS
   // The queue never holds more words than it has slots.
   assert property (@(posedge clock) disable iff (reset)
      level <= CNT_W'(RSP_DEPTH))
      else $error("result queue overflow");

   // A zero byte always leaves the decoder with no sequence open.
   assert property (@(posedge clock) disable iff (reset)
      (req_take && req_in_byte == 8'h00) |=> (pending_ff == 2'd0 && accum_ff == '0))
      else $error("sequence state not cleared by terminator");

   // Results only appear after a byte has been accepted.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_take))
      else $error("result word without an accepted byte");
`endif

endmodule
